### rtl/core/tmr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmr_pkg: shared constants and types for the tile map entry pixel renderer
// Store sizes, function codes and the pixel position bundle passed from the
// position unit to the sequencer.
// ----------------------------------------------------------------------------
package tmr_pkg;

	localparam int TILE_STORE_BYTES = 65536;
	localparam int TILE_AW          = $clog2(TILE_STORE_BYTES);
	localparam int PALETTE_SIZE     = 256;
	localparam int PAL_AW           = $clog2(PALETTE_SIZE);

	localparam int PIX_W   = 11;
	localparam int COLOR_W = 15;

	// function codes carried in tuser
	localparam logic [1:0] FN_TILE = 2'd0;
	localparam logic [1:0] FN_PAL  = 2'd1;
	localparam logic [1:0] FN_DRAW = 2'd2;

	typedef struct packed {
		logic [TILE_AW-1:0] byte_addr;
		logic [PIX_W-1:0]   px;
		logic [PIX_W-1:0]   py;
	} pix_pos_t;

endpackage

### rtl/core/tmr_tile_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmr_tile_store: byte-wide tile data memory
// One write port, one registered read port. After reset a sweep writes zero
// to every byte, one per cycle, and busy stays high until it completes.
// ----------------------------------------------------------------------------
module tmr_tile_store import tmr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               we,
	input  logic [TILE_AW-1:0] waddr,
	input  logic [7:0]         wdata,
	input  logic               re,
	input  logic [TILE_AW-1:0] raddr,
	output logic [7:0]         rdata,
	output logic               busy
);

	logic [7:0]         mem [TILE_STORE_BYTES];
	logic [TILE_AW-1:0] clr_addr_q;
	logic               busy_q;
	logic               mem_we;
	logic [TILE_AW-1:0] mem_waddr;
	logic [7:0]         mem_wdata;

	assign busy      = busy_q;
	assign mem_we    = busy_q | we;
	assign mem_waddr = busy_q ? clr_addr_q : waddr;
	assign mem_wdata = busy_q ? 8'd0 : wdata;

	// clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			busy_q     <= 1'b1;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/tmr_palette.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmr_palette: 15-bit color palette memory
// One write port, one registered read port; read data holds between reads.
// ----------------------------------------------------------------------------
module tmr_palette import tmr_pkg::*; (
	input  logic               clk,
	input  logic               we,
	input  logic [PAL_AW-1:0]  waddr,
	input  logic [COLOR_W-1:0] wdata,
	input  logic               re,
	input  logic [PAL_AW-1:0]  raddr,
	output logic [COLOR_W-1:0] rdata
);

	logic [COLOR_W-1:0] mem [PALETTE_SIZE];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/tmr_pix_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmr_pix_unit: pixel position unit
// Map the pixel counter to the tile byte address and the flipped absolute
// pixel coordinates; reused for every pixel of a draw.
// ----------------------------------------------------------------------------
module tmr_pix_unit import tmr_pkg::*; (
	input  logic [5:0] pcnt,
	input  logic [9:0] tidx,
	input  logic       hflip,
	input  logic       vflip,
	input  logic [7:0] col,
	input  logic [7:0] row,
	output pix_pos_t   pos
);

	logic [2:0] sx;
	logic [2:0] sy;

	// source x in the low bits, source y above
	assign sx = hflip ? ~pcnt[2:0] : pcnt[2:0];
	assign sy = vflip ? ~pcnt[5:3] : pcnt[5:3];

	// tile base is index*32, four bytes per row, two pixels per byte
	assign pos.byte_addr = TILE_AW'({tidx, pcnt[5:1]});
	assign pos.px        = {col, sx};
	assign pos.py        = {row, sy};

endmodule

### rtl/core/tile_map_entry_pixel_render.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_map_entry_pixel_render: 4bpp text background tile renderer
// Fill tile bytes and palette colors, then expand map entries into one
// pixel write per opaque pixel of the 8x8 tile.
// ----------------------------------------------------------------------------
// After reset the tile store is swept to zero, one byte per cycle, and
// s_axis_tready stays low until the sweep ends. A tile byte or palette
// write word is written as it is accepted. A draw word with a nonzero tile
// index walks the 64 pixels of the tile under a small sequencer that
// shares one position unit and one read port of each memory: every pixel
// takes a tile read and a nibble test, an opaque pixel also a palette read,
// and no word is accepted until the draw ends. Each opaque pixel is held
// one step in a pending register so the final write of the draw can carry
// tlast; the output register lets the next input word be taken while the
// last pixel word still waits on m_axis_tready. A tile index of zero, an
// unused function code and a fully transparent tile give no output words.
// ----------------------------------------------------------------------------
module tile_map_entry_pixel_render import tmr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// addr[15:0], wdata[30:16], entry[46:31], tile_col[54:47],
	// tile_row[62:55], front_layer[63]
	input  logic [63:0] s_axis_tdata,
	// func[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pix_x[10:0], pix_y[21:11], color[36:22], front[37], zero pad[39:38]
	output logic [39:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TREAD,
		S_TDATA,
		S_PDATA,
		S_FLUSH
	} state_t;

	state_t state_q;

	// unpack the input word
	logic [15:0] in_addr;
	logic [14:0] in_wdata;
	logic [15:0] in_entry;
	logic [7:0]  in_col;
	logic [7:0]  in_row;
	logic        in_front;
	logic        in_acc;

	assign in_addr  = s_axis_tdata[15:0];
	assign in_wdata = s_axis_tdata[30:16];
	assign in_entry = s_axis_tdata[46:31];
	assign in_col   = s_axis_tdata[54:47];
	assign in_row   = s_axis_tdata[62:55];
	assign in_front = s_axis_tdata[63];

	// draw context
	logic [5:0]  pcnt_q;
	logic [9:0]  tidx_q;
	logic        hflip_q;
	logic        vflip_q;
	logic [3:0]  bank_q;
	logic [7:0]  col_q;
	logic [7:0]  row_q;
	logic        front_q;

	// coordinates of the opaque pixel whose color is being read
	logic [PIX_W-1:0]   cur_x_q;
	logic [PIX_W-1:0]   cur_y_q;

	// pending pixel, held until the next opaque pixel or the end of the tile
	logic               pend_vld_q;
	logic [PIX_W-1:0]   pend_x_q;
	logic [PIX_W-1:0]   pend_y_q;
	logic [COLOR_W-1:0] pend_c_q;

	// output register
	logic               out_vld_q;
	logic [PIX_W-1:0]   out_x_q;
	logic [PIX_W-1:0]   out_y_q;
	logic [COLOR_W-1:0] out_c_q;
	logic               out_front_q;
	logic               out_last_q;

	logic               tile_busy;
	logic               tile_we;
	logic [7:0]         tile_rdata;
	logic               tile_re;
	logic               pal_we;
	logic               pal_re;
	logic [COLOR_W-1:0] pal_rdata;
	logic [3:0]         cidx;
	logic               slot_free;
	logic               out_load;
	pix_pos_t           pos;

	assign s_axis_tready = (state_q == S_IDLE) && !tile_busy;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// drop writes beyond either store
	assign tile_we = in_acc && (s_axis_tuser == FN_TILE) &&
		({1'b0, in_addr} < 17'(TILE_STORE_BYTES));
	assign pal_we  = in_acc && (s_axis_tuser == FN_PAL) &&
		({1'b0, in_addr} < 17'(PALETTE_SIZE));

	// even x takes the low nibble
	assign cidx    = pcnt_q[0] ? tile_rdata[7:4] : tile_rdata[3:0];
	assign tile_re = (state_q == S_TREAD);
	assign pal_re  = (state_q == S_TDATA) && (cidx != 4'd0);

	assign slot_free = !out_vld_q || m_axis_tready;

	// the pending pixel moves into the output register this cycle
	assign out_load = pend_vld_q && slot_free && (state_q inside {S_PDATA, S_FLUSH});

	tmr_pix_unit u_pix (
		.pcnt  (pcnt_q),
		.tidx  (tidx_q),
		.hflip (hflip_q),
		.vflip (vflip_q),
		.col   (col_q),
		.row   (row_q),
		.pos   (pos)
	);

	tmr_tile_store u_tile (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (tile_we),
		.waddr  (in_addr[TILE_AW-1:0]),
		.wdata  (in_wdata[7:0]),
		.re     (tile_re),
		.raddr  (pos.byte_addr),
		.rdata  (tile_rdata),
		.busy   (tile_busy)
	);

	tmr_palette u_pal (
		.clk   (clk),
		.we    (pal_we),
		.waddr (in_addr[PAL_AW-1:0]),
		.wdata (in_wdata),
		.re    (pal_re),
		.raddr ({bank_q, cidx}),
		.rdata (pal_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pcnt_q      <= '0;
			tidx_q      <= '0;
			hflip_q     <= 1'b0;
			vflip_q     <= 1'b0;
			bank_q      <= '0;
			col_q       <= '0;
			row_q       <= '0;
			front_q     <= 1'b0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			pend_vld_q  <= 1'b0;
			pend_x_q    <= '0;
			pend_y_q    <= '0;
			pend_c_q    <= '0;
			out_vld_q   <= 1'b0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_c_q     <= '0;
			out_front_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			// retire the output word once taken, unless a new one replaces it
			if (out_vld_q && m_axis_tready && !out_load) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					// start a draw for a nonzero tile index
					if (in_acc && (s_axis_tuser == FN_DRAW) && (in_entry[9:0] != 10'd0)) begin
						tidx_q  <= in_entry[9:0];
						hflip_q <= in_entry[10];
						vflip_q <= in_entry[11];
						bank_q  <= in_entry[15:12];
						col_q   <= in_col;
						row_q   <= in_row;
						front_q <= in_front;
						pcnt_q  <= '0;
						state_q <= S_TREAD;
					end
				end
				S_TREAD: begin
					state_q <= S_TDATA;
				end
				S_TDATA: begin
					if (cidx == 4'd0) begin
						// transparent: advance
						if (&pcnt_q) begin
							state_q <= S_FLUSH;
						end else begin
							pcnt_q  <= pcnt_q + 1'b1;
							state_q <= S_TREAD;
						end
					end else begin
						cur_x_q <= pos.px;
						cur_y_q <= pos.py;
						state_q <= S_PDATA;
					end
				end
				S_PDATA: begin
					// push the older pending pixel out, keep this one pending
					if (!pend_vld_q || slot_free) begin
						if (pend_vld_q) begin
							out_vld_q   <= 1'b1;
							out_x_q     <= pend_x_q;
							out_y_q     <= pend_y_q;
							out_c_q     <= pend_c_q;
							out_front_q <= front_q;
							out_last_q  <= 1'b0;
						end
						pend_vld_q <= 1'b1;
						pend_x_q   <= cur_x_q;
						pend_y_q   <= cur_y_q;
						pend_c_q   <= pal_rdata;
						if (&pcnt_q) begin
							state_q <= S_FLUSH;
						end else begin
							pcnt_q  <= pcnt_q + 1'b1;
							state_q <= S_TREAD;
						end
					end
				end
				S_FLUSH: begin
					// the pending pixel is the final write of the draw
					if (!pend_vld_q) begin
						state_q <= S_IDLE;
					end else if (slot_free) begin
						out_vld_q   <= 1'b1;
						out_x_q     <= pend_x_q;
						out_y_q     <= pend_y_q;
						out_c_q     <= pend_c_q;
						out_front_q <= front_q;
						out_last_q  <= 1'b1;
						pend_vld_q  <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {2'b00, out_front_q, out_c_q, out_y_q, out_x_q};
	assign m_axis_tlast  = out_last_q;

endmodule

### tb/tile_map_entry_pixel_render_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_map_entry_pixel_render_tb: self-checking bench for the tile renderer
// Stream tile byte, palette and draw words into the block, predict every
// pixel write from a mirror of both stores, and compare the output words in
// order. Random idle on both sides, plus one long output hold-off.
// ----------------------------------------------------------------------------
module tile_map_entry_pixel_render_tb;
	import tmr_pkg::*;

	// unused function code: the block must drop it
	localparam logic [1:0] FN_UNUSED = 2'd3;

	localparam int WORD_TARGET  = 410;
	localparam int IDLE_PCT     = 13;
	localparam int CALM_FIRST   = 150;   // no idling on either side from this word
	localparam int CALM_LAST    = 260;   // ... up to this one
	localparam int HOLD_AFTER   = 80;    // pixels seen before the long hold-off
	localparam int HOLD_CYCLES  = 1000;
	localparam int DRAIN_CYCLES = 400;   // longer than the slowest draw
	localparam int CYCLE_LIMIT  = 1500000;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] addr;
		logic [14:0] wdata;
		logic [15:0] entry;
		logic [7:0]  col;
		logic [7:0]  row;
		logic        front_layer;
	} word_t;

	typedef struct packed {
		logic [PIX_W-1:0]   x;
		logic [PIX_W-1:0]   y;
		logic [COLOR_W-1:0] color;
		logic               front;
		logic               last;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// addr[15:0], wdata[30:16], entry[46:31], tile_col[54:47],
	// tile_row[62:55], front_layer[63]
	logic [63:0] s_axis_tdata = '0;
	// func[1:0]
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// pix_x[10:0], pix_y[21:11], color[36:22], front[37], zero pad[39:38]
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	// mirror of the block's stores, updated as words are accepted
	logic [7:0]         tile_mem [0:TILE_STORE_BYTES-1];
	logic [COLOR_W-1:0] pal_mem  [0:PALETTE_SIZE-1];

	// stimulus side: which palette entries the queued words have written
	bit    pal_filled [0:PALETTE_SIZE-1];
	int    drawn_tiles [$];
	word_t word_q [$];
	word_t cur_word;
	word_t next_word;

	// pixel writes predicted but not yet seen on the output
	pixel_t pix_due [$];
	pixel_t got_pix;
	pixel_t want_pix;

	int  words_in = 0;
	int  pix_seen = 0;
	int  hold_cnt = 0;
	bit  hold_done = 1'b0;
	int  errors = 0;
	int  total_words;
	int  cycle_cnt;
	wire calm = (words_in >= CALM_FIRST) && (words_in < CALM_LAST);

	tile_map_entry_pixel_render u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		foreach (tile_mem[i])
			tile_mem[i] = 8'h00;
		foreach (pal_mem[i])
			pal_mem[i] = '0;
	end

	// ------------------------------------------------------------------
	// Pixel predictor: apply one accepted word to the mirrored stores and
	// queue the pixel writes a draw produces, scanning rows then columns.
	// ------------------------------------------------------------------
	function automatic void apply_word(input word_t w);
		logic [9:0] tidx;
		logic [7:0] v;
		logic [3:0] ci;
		logic [2:0] px;
		logic [2:0] py;
		pixel_t     p;
		int         n;
		n = 0;
		case (w.func)
			FN_TILE: begin
				tile_mem[w.addr] = w.wdata[7:0];
			end
			FN_PAL: begin
				// indexes past the palette are dropped
				if (w.addr < PALETTE_SIZE)
					pal_mem[w.addr[PAL_AW-1:0]] = w.wdata;
			end
			FN_DRAW: begin
				tidx = w.entry[9:0];
				if (tidx != 10'd0) begin
					for (int y = 0; y < 8; y++) begin
						for (int x = 0; x < 8; x++) begin
							// two pixels per byte, even x in the low nibble
							v = tile_mem[{1'b0, tidx, 3'(y), 2'(x / 2)}];
							ci = (x % 2 == 1) ? v[7:4] : v[3:0];
							if (ci != 4'd0) begin
								px = w.entry[10] ? 3'(7 - x) : 3'(x);
								py = w.entry[11] ? 3'(7 - y) : 3'(y);
								p.x = {w.col, px};
								p.y = {w.row, py};
								p.color = pal_mem[{w.entry[15:12], ci}];
								p.front = w.front_layer;
								p.last = 1'b0;
								pix_due.push_back(p);
								n++;
							end
						end
					end
				end
				// mark the final write of the draw
				if (n != 0) begin
					p = pix_due.pop_back();
					p.last = 1'b1;
					pix_due.push_back(p);
				end
			end
			default: begin
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic word_t rand_word();
		word_t w;
		w.func = FN_UNUSED;
		w.addr = 16'($urandom);
		w.wdata = 15'($urandom);
		w.entry = 16'($urandom);
		w.col = 8'($urandom);
		w.row = 8'($urandom);
		w.front_layer = 1'($urandom);
		return w;
	endfunction

	function automatic void push_word(input word_t w);
		if (w.func == FN_PAL && w.addr < PALETTE_SIZE)
			pal_filled[w.addr[PAL_AW-1:0]] = 1'b1;
		word_q.push_back(w);
	endfunction

	function automatic bit bank_ready(input logic [3:0] b);
		for (int i = 1; i < 16; i++)
			if (!pal_filled[{b, 4'(i)}])
				return 1'b0;
		return 1'b1;
	endfunction

	// mostly reuse banks that are already filled, to keep palette traffic down
	function automatic logic [3:0] pick_bank();
		logic [3:0] b;
		b = 4'($urandom_range(15));
		if ($urandom_range(99) < 75)
			repeat (16)
				if (!bank_ready(b))
					b = b + 4'd1;
		return b;
	endfunction

	// fill any palette entry the draw could read before it goes out;
	// entry 0 of a bank is transparent and never read
	function automatic void queue_draw(input logic [15:0] entry);
		word_t w;
		if (entry[9:0] != 10'd0) begin
			for (int i = 1; i < 16; i++) begin
				if (!pal_filled[{entry[15:12], 4'(i)}]) begin
					w = rand_word();
					w.func = FN_PAL;
					w.addr = {8'd0, entry[15:12], 4'(i)};
					push_word(w);
				end
			end
		end
		w = rand_word();
		w.func = FN_DRAW;
		w.entry = entry;
		push_word(w);
	endfunction

	function automatic void queue_tile(input logic [9:0] tidx);
		word_t w;
		int    pct;
		case ($urandom_range(4))
			0: pct = 0;
			1: pct = 15;
			2: pct = 50;
			3: pct = 85;
			default: pct = 100;
		endcase
		for (int i = 0; i < 32; i++) begin
			w = rand_word();
			w.func = FN_TILE;
			w.addr = {1'b0, tidx, 5'(i)};
			w.wdata[3:0] = ($urandom_range(99) < pct) ? 4'($urandom_range(1, 15)) : 4'd0;
			w.wdata[7:4] = ($urandom_range(99) < pct) ? 4'($urandom_range(1, 15)) : 4'd0;
			push_word(w);
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus build, reset, and end of run
	// ------------------------------------------------------------------
	initial begin
		word_t    w;
		logic [9:0] tidx;
		int       r;

		// directed: palette index past the end, then only the colors that
		// the directed tile uses (indexes 1 and 15 of banks 0 and 15)
		w = rand_word(); w.func = FN_PAL; w.addr = 16'hFFFF; w.wdata = 15'h7FFF; push_word(w);
		w = rand_word(); w.func = FN_PAL; w.addr = 16'd256; w.wdata = 15'h1234; push_word(w);
		w = rand_word(); w.func = FN_PAL; w.addr = 16'd241; w.wdata = 15'h7FFF; push_word(w);
		w = rand_word(); w.func = FN_PAL; w.addr = 16'd255; w.wdata = 15'h0000; push_word(w);
		w = rand_word(); w.func = FN_PAL; w.addr = 16'd1;   w.wdata = 15'h2AAA; push_word(w);
		w = rand_word(); w.func = FN_PAL; w.addr = 16'd15;  w.wdata = 15'h5555; push_word(w);

		// top byte of the store, upper wdata bits must not land
		w = rand_word(); w.func = FN_TILE; w.addr = 16'hFFFF; w.wdata = 15'h7FFF; push_word(w);

		// tile index zero (plain and with every other bit set), an unwritten
		// all-transparent tile, and the unused function code
		w = rand_word(); w.func = FN_DRAW; w.entry = 16'h0000; push_word(w);
		w = rand_word(); w.func = FN_DRAW; w.entry = 16'hFC00; push_word(w);
		w = rand_word(); w.func = FN_DRAW; w.entry = 16'hF005; push_word(w);
		w = rand_word(); w.func = FN_UNUSED; push_word(w);

		// tile 1023: first and last byte, pixels at two corners with color indexes 1 and 15
		w = rand_word(); w.func = FN_TILE; w.addr = 16'd32736; w.wdata = 15'h7FF1; push_word(w);
		w = rand_word(); w.func = FN_TILE; w.addr = 16'd32767; w.wdata = 15'h001F; push_word(w);

		// every flip combination, both layers, both ends of the map
		w = rand_word(); w.func = FN_DRAW; w.entry = 16'hFFFF;
		w.col = 8'd255; w.row = 8'd255; w.front_layer = 1'b1; push_word(w);
		w = rand_word(); w.func = FN_DRAW; w.entry = 16'hFFFF;
		w.col = 8'd0; w.row = 8'd0; w.front_layer = 1'b0; push_word(w);
		w = rand_word(); w.func = FN_DRAW; w.entry = 16'hF3FF;
		w.col = 8'd0; w.row = 8'd0; push_word(w);
		w = rand_word(); w.func = FN_DRAW; w.entry = 16'hF7FF; push_word(w);
		w = rand_word(); w.func = FN_DRAW; w.entry = 16'hFBFF; push_word(w);
		w = rand_word(); w.func = FN_DRAW; w.entry = 16'h0FFF; push_word(w);

		// random part: mostly fill-a-tile-then-draw sequences and redraws
		// of known tiles; the rest is stray writes and odd draws
		while (word_q.size() < WORD_TARGET) begin
			r = $urandom_range(99);
			if (r < 22 || (r < 55 && drawn_tiles.size() == 0)) begin
				tidx = 10'($urandom_range(1, 1023));
				queue_tile(tidx);
				drawn_tiles.push_back(tidx);
				queue_draw({pick_bank(), 2'($urandom), tidx});
			end else if (r < 55) begin
				tidx = 10'(drawn_tiles[$urandom_range(drawn_tiles.size() - 1)]);
				queue_draw({pick_bank(), 2'($urandom), tidx});
			end else if (r < 70) begin
				w = rand_word();
				w.func = FN_PAL;
				if ($urandom_range(9) != 0)
					w.addr = 16'($urandom_range(PALETTE_SIZE - 1));
				push_word(w);
			end else if (r < 82) begin
				w = rand_word();
				w.func = FN_TILE;
				push_word(w);
			end else if (r < 90) begin
				w = rand_word();
				queue_draw({pick_bank(), w.entry[11:0]});
			end else if (r < 95) begin
				w = rand_word();
				push_word(w);
			end else begin
				w = rand_word();
				queue_draw({w.entry[15:10], 10'd0});
			end
		end
		total_words = word_q.size();

		// hold reset, then release away from the rising edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// the store sweep after reset holds tready low for a while first
		while (words_in < total_words)
			@(posedge clk);
		while (pix_due.size() != 0)
			@(posedge clk);
		// catch any stray write after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("%0t: timeout after %0d cycles, %0d words in, %0d pixels due",
			$time, cycle_cnt, words_in, pix_due.size());
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Driver: predict each word on acceptance, then offer the next one
	// unless idling. Valid is never dropped while a word waits.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			words_in <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				apply_word(cur_word);
				words_in <= words_in + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (word_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					next_word = word_q.pop_front();
					cur_word <= next_word;
					s_axis_tdata <= {next_word.front_layer, next_word.row, next_word.col,
						next_word.entry, next_word.wdata, next_word.addr};
					s_axis_tuser <= next_word.func;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Long hold-off: once enough pixels have come out, keep the output
	// stalled so the block backs up while the driver keeps offering words.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
			hold_done <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (!hold_done && pix_seen >= HOLD_AFTER) begin
			hold_cnt <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare each output word against the oldest prediction
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			pix_seen <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_pix.x = m_axis_tdata[10:0];
				got_pix.y = m_axis_tdata[21:11];
				got_pix.color = m_axis_tdata[36:22];
				got_pix.front = m_axis_tdata[37];
				got_pix.last = m_axis_tlast;
				pix_seen <= pix_seen + 1;
				if (pix_due.size() == 0) begin
					$display("%0t: unexpected pixel write, expected none, got %0h",
						$time, got_pix);
					errors++;
				end else begin
					want_pix = pix_due.pop_front();
					check_field("pix_x", want_pix.x, got_pix.x);
					check_field("pix_y", want_pix.y, got_pix.y);
					check_field("color", want_pix.color, got_pix.color);
					check_field("front", want_pix.front, got_pix.front);
					check_field("last", want_pix.last, got_pix.last);
				end
			end
			m_axis_tready <= (hold_cnt == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
		end
	end

endmodule
